// ===== sv/graph_diameter_all_pairs_top_defines.svh =====
// Assertion macros shared by the checker of the graph diameter block.
`ifndef GRAPH_DIAMETER_ALL_PAIRS_TOP_DEFINES_SVH
`define GRAPH_DIAMETER_ALL_PAIRS_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define GDAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define GDAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`endif

// ===== sv/gdap_pkg.sv =====
// Package of the graph diameter block: payload types, control struct and constants.
`timescale 1ns / 1ps
package gdap_pkg;

  localparam logic [5:0] DIST_INF       = 6'h3F;
  localparam logic [5:0] DIAM_MAX       = 6'd31;
  localparam logic [5:0] NODE_COUNT_RST = 6'd32;
  localparam logic       CMD_EDGE       = 1'b0;
  localparam logic       CMD_COMPUTE    = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [4:0] node_a;
    logic [4:0] node_b;
  } gdap_in_t;

  typedef struct packed {
    logic [4:0] diameter;
    logic       disconnected;
  } gdap_out_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic clr_en;
    logic edge_en;
    logic relax_vld;
    logic ik_ld;
    logic scan_vld;
    logic scan_diag;
    logic acc_clr;
    logic report;
  } gdap_ctl_t;

endpackage

// ===== sv/graph_diameter_all_pairs_top.sv =====
// Top level of the graph diameter block: all-pairs shortest paths over a loaded edge list.
// Use of the block:
// An input transaction is taken at a rising edge with start high and busy low. With cmd
// at CMD_EDGE it stores the undirected edge node_a-node_b; self edges and endpoints at or
// above the node count are dropped. A valid edge keeps busy high through the S_EDGE state,
// which writes the reverse entry; a dropped one leaves busy low.
// With cmd at CMD_COMPUTE the block runs Floyd-Warshall over n nodes (n is node_count
// held to MAX_NODES) on one shared add-and-compare unit fed by a two-read-port memory:
// n*n row set-ups plus n*n*n relax steps, then a scan of the n*n entries for the diameter,
// and the S_DRAIN state to form the result. out_valid then pulses for a single cycle with
// diameter and disconnected; the receiver cannot hold it off.
// After the report the memory is swept back to its initial contents, one entry a cycle,
// over all 2**(2*clog2(MAX_NODES)) entries (1024 at MAX_NODES of 32); busy stays high meanwhile.
// Reset is synchronous and active low; after it the same sweep runs before start is taken,
// and node_count returns to 32. The configuration channel (cfg_valid, cfg_ready, cfg_data)
// is always ready and should be written only while the block is idle.
`timescale 1ns / 1ps
module graph_diameter_all_pairs_top #(
  parameter int MAX_NODES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gdap_pkg::gdap_in_t  in_data,
  output logic                out_valid,
  output gdap_pkg::gdap_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);

  localparam int AW = 2 * $clog2(MAX_NODES);

  gdap_pkg::gdap_ctl_t ctl;
  logic [AW-1:0]       rd_a_addr, rd_b_addr, wr_addr;

  gdap_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr_addr   (wr_addr)
  );

  gdap_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr_addr   (wr_addr),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/gdap_seq.sv =====
// Sequencer of the graph diameter block: node count register, loop counters and phases.
`timescale 1ns / 1ps
module gdap_seq #(
  parameter int MAX_NODES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  gdap_pkg::gdap_in_t              in_data,
  output logic                            busy,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [5:0]                      cfg_data,
  output gdap_pkg::gdap_ctl_t             ctl,
  output logic [2*$clog2(MAX_NODES)-1:0]  rd_a_addr,
  output logic [2*$clog2(MAX_NODES)-1:0]  rd_b_addr,
  output logic [2*$clog2(MAX_NODES)-1:0]  wr_addr
);

  localparam int IW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int CMPW = (NCW > 6) ? NCW : 6;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EDGE  = 7'b0000100,
    S_IK    = 7'b0001000,
    S_ROW   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_DRAIN = 7'b1000000
  } gdap_state_t;

  gdap_state_t state_r, state_nxt;
  logic [5:0]    node_count_r;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic [CMPW-1:0] cnt_ext, max_ext, n_sat;
  logic [NCW-1:0]  n_eff;
  logic [IW-1:0]   last_idx;
  logic            accept, edge_ok, i_last, j_last, k_last;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  // Node count saturated to the array size.
  assign cnt_ext  = CMPW'(node_count_r);
  assign max_ext  = CMPW'(MAX_NODES);
  assign n_sat    = (cnt_ext > max_ext) ? max_ext : cnt_ext;
  assign n_eff    = NCW'(n_sat);
  assign last_idx = IW'(n_eff - NCW'(1));

  assign edge_ok = (in_data.node_a != in_data.node_b)
                && (CMPW'(in_data.node_a) < n_sat)
                && (CMPW'(in_data.node_b) < n_sat);

  assign i_last = (i_r == last_idx);
  assign j_last = (j_r == last_idx);
  assign k_last = (k_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ctl       = '0;
    rd_a_addr = {i_r, j_r};
    rd_b_addr = {k_r, j_r};
    wr_addr   = {i_r, j_r};
    case (state_r)
      S_CLEAR: begin
        ctl.clr_en = 1'b1;
        {i_nxt, j_nxt} = {i_r, j_r} + (2*IW)'(1);
        if (&{i_r, j_r}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        wr_addr = {IW'(in_data.node_a), IW'(in_data.node_b)};
        if (accept) begin
          if (in_data.cmd == gdap_pkg::CMD_EDGE) begin
            if (edge_ok) begin
              ctl.edge_en = 1'b1;
              i_nxt       = IW'(in_data.node_b);
              j_nxt       = IW'(in_data.node_a);
              state_nxt   = S_EDGE;
            end
          end else begin
            ctl.acc_clr = 1'b1;
            i_nxt       = '0;
            j_nxt       = '0;
            k_nxt       = '0;
            state_nxt   = (n_eff == '0) ? S_DRAIN : S_IK;
          end
        end
      end
      S_EDGE: begin
        ctl.edge_en = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IK: begin
        rd_a_addr = {i_r, k_r};
        ctl.ik_ld = 1'b1;
        j_nxt     = '0;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        ctl.relax_vld = 1'b1;
        if (j_last) begin
          if (i_last) begin
            i_nxt = '0;
            if (k_last) begin
              j_nxt     = '0;
              state_nxt = S_SCAN;
            end else begin
              k_nxt     = k_r + IW'(1);
              state_nxt = S_IK;
            end
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_IK;
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_SCAN: begin
        ctl.scan_vld  = 1'b1;
        ctl.scan_diag = (i_r == j_r);
        if (j_last) begin
          j_nxt = '0;
          if (i_last) begin
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_DRAIN: begin
        ctl.report = 1'b1;
        i_nxt      = '0;
        j_nxt      = '0;
        state_nxt  = S_CLEAR;
      end
      default: begin
        state_nxt = S_CLEAR;
        i_nxt     = '0;
        j_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      node_count_r <= gdap_pkg::NODE_COUNT_RST;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
  end

endmodule

// ===== sv/gdap_dpath.sv =====
// Datapath of the graph diameter block: distance memory, shared relax unit and result scan.
`timescale 1ns / 1ps
module gdap_dpath #(
  parameter int MAX_NODES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gdap_pkg::gdap_ctl_t             ctl,
  input  logic [2*$clog2(MAX_NODES)-1:0]  rd_a_addr,
  input  logic [2*$clog2(MAX_NODES)-1:0]  rd_b_addr,
  input  logic [2*$clog2(MAX_NODES)-1:0]  wr_addr,
  output logic                            out_valid,
  output gdap_pkg::gdap_out_t             out_data
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  logic [5:0] mem_r [DEPTH];
  logic [5:0] rd_a_r, rd_b_r, ik_r;

  logic          ik_ld_r, rl_vld_r, sc_vld_r, sc_diag_r;
  logic [AW-1:0] rl_addr_r;

  logic [5:0] max_r, max_nxt;
  logic       disc_r, disc_nxt;

  logic            out_valid_r;
  gdap_pkg::gdap_out_t out_data_r;

  logic [6:0]    sum_w;
  logic          rl_upd;
  logic          wr_en;
  logic [AW-1:0] wr_addr_w;
  logic [5:0]    wr_data_w;

  // Shared relax unit: d[i][j] = d[i][k] + d[k][j] when that is shorter.
  assign sum_w  = {1'b0, ik_r} + {1'b0, rd_b_r};
  assign rl_upd = rl_vld_r && (ik_r != gdap_pkg::DIST_INF)
               && (rd_b_r != gdap_pkg::DIST_INF) && (sum_w < {1'b0, rd_a_r});

  always_comb begin
    wr_en     = 1'b0;
    wr_addr_w = wr_addr;
    wr_data_w = gdap_pkg::DIST_INF;
    if (ctl.clr_en) begin
      wr_en = 1'b1;
      if (wr_addr[AW-1:IW] == wr_addr[IW-1:0]) begin
        wr_data_w = '0;
      end
    end else if (ctl.edge_en) begin
      wr_en     = 1'b1;
      wr_data_w = 6'd1;
    end else if (rl_upd) begin
      wr_en     = 1'b1;
      wr_addr_w = rl_addr_r;
      wr_data_w = sum_w[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr_w] <= wr_data_w;
    end
    rd_a_r <= mem_r[rd_a_addr];
    rd_b_r <= mem_r[rd_b_addr];
  end

  // Largest off-diagonal distance seen so far, and whether any was infinite.
  always_comb begin
    max_nxt  = max_r;
    disc_nxt = disc_r;
    if (sc_vld_r && !sc_diag_r) begin
      if (rd_a_r == gdap_pkg::DIST_INF) begin
        disc_nxt = 1'b1;
      end else if (rd_a_r > max_r) begin
        max_nxt = rd_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ik_ld_r     <= 1'b0;
      rl_vld_r    <= 1'b0;
      sc_vld_r    <= 1'b0;
      sc_diag_r   <= 1'b0;
      max_r       <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ik_ld_r     <= ctl.ik_ld;
      rl_vld_r    <= ctl.relax_vld;
      sc_vld_r    <= ctl.scan_vld;
      sc_diag_r   <= ctl.scan_diag;
      out_valid_r <= ctl.report;
      if (ctl.acc_clr) begin
        max_r  <= '0;
        disc_r <= 1'b0;
      end else begin
        max_r  <= max_nxt;
        disc_r <= disc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rl_addr_r <= rd_a_addr;
    if (ik_ld_r) begin
      ik_r <= rd_a_r;
    end
    if (ctl.report) begin
      out_data_r.disconnected <= disc_nxt;
      if (disc_nxt) begin
        out_data_r.diameter <= '0;
      end else if (max_nxt > gdap_pkg::DIAM_MAX) begin
        out_data_r.diameter <= gdap_pkg::DIAM_MAX[4:0];
      end else begin
        out_data_r.diameter <= max_nxt[4:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/gdap_checker.sv =====
// Port-level checker of the graph diameter block, bound to the top level.
`timescale 1ns / 1ps
`include "graph_diameter_all_pairs_top_defines.svh"
module gdap_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input gdap_pkg::gdap_in_t  in_data,
  input logic                out_valid,
  input gdap_pkg::gdap_out_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [5:0]          cfg_data
);

  logic compute_accept;
  logic edge_accept;
  logic cfg_write;

  assign compute_accept = start && !busy && (in_data.cmd == gdap_pkg::CMD_COMPUTE);
  assign edge_accept    = start && !busy && (in_data.cmd == gdap_pkg::CMD_EDGE);
  assign cfg_write      = cfg_valid && cfg_ready && (cfg_data == cfg_data);

  // A result belongs to a running compute transaction; the clearing sweep follows it.
  `GDAP_ASSERT_NOW(a_result_while_busy, out_valid, busy)
  // Each compute transaction yields a single one-cycle result.
  `GDAP_ASSERT_NEXT(a_result_single_pulse, out_valid, !out_valid)
  // A disconnected graph reports a diameter of zero.
  `GDAP_ASSERT_NOW(a_disc_zero_diam, out_valid && out_data.disconnected, out_data.diameter == 5'd0)
  // A compute transaction always occupies the block in the following cycle.
  `GDAP_ASSERT_NEXT(a_compute_goes_busy, compute_accept, busy)
  // Neither an edge transaction nor a configuration write while idle produces a result in the next cycle.
  `GDAP_ASSERT_NEXT(a_edge_no_result, edge_accept || (cfg_write && !busy), !out_valid)

endmodule

bind graph_diameter_all_pairs_top gdap_checker u_gdap_checker (.*);

// ===== verif/tb_graph_diameter_all_pairs_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the graph diameter block: directed table, then random graphs.
module tb_graph_diameter_all_pairs_top;

  localparam int NODES       = 32;
  localparam int ITEM_TARGET = 700;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int NUM_PHASES  = 18;

  // Node counts walked by the random part; 63 and 33 saturate to 32 inside the block.
  localparam logic [5:0] PHASE_NODES [NUM_PHASES] = '{
    6'd4, 6'd8, 6'd2, 6'd6, 6'd32, 6'd5, 6'd12, 6'd3, 6'd63,
    6'd7, 6'd16, 6'd1, 6'd10, 6'd0, 6'd8, 6'd33, 6'd6, 6'd4
  };
  // The receiver cannot stall, so only the sender's share of idling matters here.
  localparam int PHASE_IDLE [4] = '{0, 55, 0, 14};

  typedef struct {
    bit                  is_cfg;
    logic [5:0]          cfg_val;
    gdap_pkg::gdap_in_t  item;
    bit                  typed;
    gdap_pkg::gdap_out_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  gdap_pkg::gdap_in_t  in_data;
  logic                out_valid;
  gdap_pkg::gdap_out_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [5:0]          cfg_data;

  graph_diameter_all_pairs_top #(.MAX_NODES(NODES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's distance matrix and node count register.
  logic [5:0]          dist_mat [NODES][NODES];
  logic [5:0]          node_count_q;
  gdap_pkg::gdap_out_t diam_expect_q [$];
  dir_row_t            dir_rows [$];

  int err_count     = 0;
  int reports_seen  = 0;
  int cycle_count   = 0;
  int accepted_cmds = 0;
  int idle_pct      = 0;

  function automatic void clear_dist();
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        dist_mat[i][j] = (i == j) ? 6'd0 : gdap_pkg::DIST_INF;
  endfunction

  function automatic int eff_nodes();
    return (node_count_q > NODES) ? NODES : int'(node_count_q);
  endfunction

  // All-pairs shortest paths over the active nodes, then the diameter scan and the clear.
  function automatic gdap_pkg::gdap_out_t solve_diameter();
    int                  n;
    int                  ik;
    int                  kj;
    int                  diam;
    bit                  disc;
    gdap_pkg::gdap_out_t r;
    n    = eff_nodes();
    diam = 0;
    disc = 1'b0;
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          ik = dist_mat[i][k];
          kj = dist_mat[k][j];
          if (ik != gdap_pkg::DIST_INF && kj != gdap_pkg::DIST_INF &&
              ik + kj < dist_mat[i][j])
            dist_mat[i][j] = 6'(ik + kj);
        end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (i != j) begin
          if (dist_mat[i][j] == gdap_pkg::DIST_INF) disc = 1'b1;
          else if (dist_mat[i][j] > diam) diam = dist_mat[i][j];
        end
      end
    if (disc) diam = 0;
    if (diam > gdap_pkg::DIAM_MAX) diam = gdap_pkg::DIAM_MAX;
    r.diameter     = 5'(diam);
    r.disconnected = disc;
    clear_dist();
    return r;
  endfunction

  function automatic void note_mismatch(string what, gdap_pkg::gdap_out_t want,
                                        gdap_pkg::gdap_out_t got);
    err_count++;
    if (err_count <= 10)
      $display("%t: %s: expected diameter %0d disconnected %0d, got diameter %0d disconnected %0d",
               $realtime, what, want.diameter, want.disconnected, got.diameter,
               got.disconnected);
  endfunction

  function automatic dir_row_t row(bit is_cfg, int v, logic cmd, int a, int b,
                                   bit typed, int diam, bit disc);
    dir_row_t r;
    r.is_cfg            = is_cfg;
    r.cfg_val           = 6'(v);
    r.item.cmd          = cmd;
    r.item.node_a       = 5'(a);
    r.item.node_b       = 5'(b);
    r.typed             = typed;
    r.want.diameter     = 5'(diam);
    r.want.disconnected = disc;
    return r;
  endfunction

  // Offers one command and updates the shadow state at the edge that accepts it.
  task automatic issue_cmd(input gdap_pkg::gdap_in_t it, input bit typed,
                           input gdap_pkg::gdap_out_t want);
    gdap_pkg::gdap_out_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    accepted_cmds++;
    if (it.cmd == gdap_pkg::CMD_COMPUTE) begin
      res = solve_diameter();
      diam_expect_q.push_back(typed ? want : res);
    end else if (it.node_a != it.node_b && it.node_a < eff_nodes() &&
                 it.node_b < eff_nodes()) begin
      dist_mat[it.node_a][it.node_b] = 6'd1;
      dist_mat[it.node_b][it.node_a] = 6'd1;
    end
  endtask

  task automatic send_link(input int a, input int b);
    gdap_pkg::gdap_in_t it;
    it.cmd = gdap_pkg::CMD_EDGE;
    if ($urandom_range(1)) begin
      it.node_a = 5'(a);
      it.node_b = 5'(b);
    end else begin
      it.node_a = 5'(b);
      it.node_b = 5'(a);
    end
    issue_cmd(it, 1'b0, '0);
  endtask

  task automatic send_compute();
    gdap_pkg::gdap_in_t it;
    it.cmd    = gdap_pkg::CMD_COMPUTE;
    it.node_a = 5'($urandom_range(31));
    it.node_b = 5'($urandom_range(31));
    issue_cmd(it, 1'b0, '0);
  endtask

  // Drops start, waits for every report and for the block to go idle again.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk);
    while (diam_expect_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [5:0] v);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    node_count_q = v;
  endtask

  // One graph over the active nodes under a random relabelling, usually followed by a compute.
  task automatic random_graph(input bit force_path);
    int n;
    int kind;
    int j;
    int tmp;
    int perm [NODES];
    n = eff_nodes();
    for (int i = 0; i < NODES; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    kind = force_path ? 5 : $urandom_range(9);
    if (n < 2 || kind == 9) begin
      // Endpoints over the whole field range: mostly self or out-of-range links.
      repeat ($urandom_range(1, 6)) send_link($urandom_range(31), $urandom_range(31));
    end else if (kind <= 4) begin
      for (int i = 1; i < n; i++) begin
        send_link(perm[i], perm[$urandom_range(i - 1)]);
        if ($urandom_range(9) == 0) send_link($urandom_range(31), $urandom_range(31));
      end
      repeat ($urandom_range(0, n / 2))
        send_link(perm[$urandom_range(n - 1)], perm[$urandom_range(n - 1)]);
    end else if (kind <= 6) begin
      for (int i = 1; i < n; i++) send_link(perm[i - 1], perm[i]);
    end else begin
      repeat ($urandom_range(1, n)) send_link($urandom_range(n - 1), $urandom_range(n - 1));
    end
    // Now and then the links are left in place and carry over into the next graph.
    if (force_path || $urandom_range(9) != 0) send_compute();
  endtask

  // Report checker: the receiver cannot stall, so every strobe is one transaction.
  always @(posedge clk) begin : report_check
    gdap_pkg::gdap_out_t want;
    if (rst_n) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_graph_diameter_all_pairs_top: done, errors");
        $finish;
      end else if (out_valid) begin
        if (diam_expect_q.size() == 0) begin
          note_mismatch("report with nothing outstanding", '0, out_data);
        end else begin
          want = diam_expect_q.pop_front();
          reports_seen++;
          if (out_data.diameter !== want.diameter)
            note_mismatch("diameter mismatch", want, out_data);
          if (out_data.disconnected !== want.disconnected)
            note_mismatch("disconnected mismatch", want, out_data);
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_start;
    int graphs;
    int cap;
    int directed_items;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    node_count_q = gdap_pkg::NODE_COUNT_RST;
    clear_dist();

    // Directed part: empty graph, zero and one node, dropped links, saturated count,
    // links that survive a count change, and a small cycle left to the predictor.
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 0, 1));
    dir_rows.push_back(row(1, 0, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 31, 31, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 31, 31, 1, 0, 0));
    dir_rows.push_back(row(1, 1, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 0, 0));
    dir_rows.push_back(row(1, 2, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 1, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 0, 31, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 0, 1));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 1, 0));
    dir_rows.push_back(row(1, 3, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 2, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 2, 0));
    dir_rows.push_back(row(1, 63, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 31, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 30, 31, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 31, 31, 1, 0, 1));
    dir_rows.push_back(row(1, 32, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(1, 2, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 1, 1, 0));
    dir_rows.push_back(row(1, 4, gdap_pkg::CMD_EDGE, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 0, 1, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 1, 2, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 2, 3, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_EDGE, 3, 0, 0, 0, 0));
    dir_rows.push_back(row(0, 0, gdap_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) write_node_count(dir_rows[r].cfg_val);
      else issue_cmd(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end
    directed_items = accepted_cmds;

    // Random part: each phase sets a node count and a sender idling rate.
    phase = 0;
    while (accepted_cmds < ITEM_TARGET) begin
      write_node_count(PHASE_NODES[phase % NUM_PHASES]);
      idle_pct    = PHASE_IDLE[phase % 4];
      phase_start = accepted_cmds;
      graphs      = 0;
      // Large graphs are slow to compute, so few of them are run.
      cap = (eff_nodes() >= 24) ? 1 : (eff_nodes() >= 12) ? 2 : (eff_nodes() < 2) ? 4 : 1000;
      while (accepted_cmds - phase_start < 45 && graphs < cap) begin
        random_graph(eff_nodes() == NODES && node_count_q == NODES);
        graphs++;
      end
      phase++;
    end

    settle_block();
    repeat (16) @(posedge clk);
    if (diam_expect_q.size() != 0) begin
      $display("%0d diameter reports never arrived", diam_expect_q.size());
      err_count += diam_expect_q.size();
    end

    $display("covered %0d directed and %0d random commands over %0d node-count phases",
             directed_items, accepted_cmds - directed_items, phase);
    $display("%0d diameter reports checked, %0d mismatches", reports_seen, err_count);
    if (err_count == 0) begin
      $display("tb_graph_diameter_all_pairs_top: done, clean");
    end else begin
      $display("tb_graph_diameter_all_pairs_top: done, errors");
    end
    $finish;
  end

endmodule
